>>> src/sbh_pkg.sv
// sbh_pkg: shared types and constants for the string bucket hash engine
// hash mode codes, configuration register indexes, back-end state type
// no dependencies
package sbh_pkg;

  // hash mode codes as held in the mode register
  typedef enum logic [2:0] {
    MODE_FIRST = 3'd0,
    MODE_LEN   = 3'd1,
    MODE_SUM   = 3'd2,
    MODE_ROTX  = 3'd3,
    MODE_OAAT  = 3'd4
  } sbh_mode_e;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 25;
  localparam logic [CfgIdxW-1:0] CFG_HASH_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUCKET_COUNT = 2'd1;

  // register widths and reset values
  localparam int unsigned ModeW   = 3;
  localparam int unsigned BucketW = 25;
  localparam logic [BucketW-1:0] BucketReset = 25'd1024;
  localparam logic [BucketW-1:0] BucketMax   = 25'h100_0000;

  // item fields
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 32;
  localparam int unsigned RawW     = 32;
  localparam int unsigned BktIdxW  = 24;
  localparam int unsigned OutDataW = 56;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIN1,
    BK_FIN2,
    BK_DIV,
    BK_OUT
  } sbh_bk_state_e;

  // unused mode codes behave as one-at-a-time
  function automatic sbh_mode_e clamp_mode(input logic [ModeW-1:0] code);
    sbh_mode_e m;
    unique case (code)
      MODE_FIRST: m = MODE_FIRST;
      MODE_LEN:   m = MODE_LEN;
      MODE_SUM:   m = MODE_SUM;
      MODE_ROTX:  m = MODE_ROTX;
      default:    m = MODE_OAAT;
    endcase
    return m;
  endfunction

  // zero acts as one, oversized counts act as the maximum
  function automatic logic [BucketW-1:0] clamp_bucket(input logic [BucketW-1:0] cnt);
    logic [BucketW-1:0] r;
    if (cnt == '0) begin
      r = BucketW'(1);
    end else if (cnt > BucketMax) begin
      r = BucketMax;
    end else begin
      r = cnt;
    end
    return r;
  endfunction

endpackage

>>> src/sbh_front.sv
// sbh_front: per-byte hash folding, length count and first-byte capture
// pushes one pre-finalised value per key into the key queue
// depends on sbh_pkg
module sbh_front #(
  parameter int unsigned HashW = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sbh_pkg::sbh_mode_e       mode_i,
  input  logic                     byte_valid_i,
  output logic                     byte_ready_o,
  input  logic [7:0]               key_byte_i,
  input  logic                     key_end_i,
  output logic                     push_o,
  output logic [HashW:0]           entry_o,
  input  logic                     full_i
);
  import sbh_pkg::*;

  logic [HashW-1:0]  hash_q, hash_d;
  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  first_q, first_d;
  logic              start_q, start_d;

  logic              take;
  logic [HashW-1:0]  byte_ext;
  logic [HashW-1:0]  fold;
  logic [HashW-1:0]  oa_t1, oa_t2;
  logic [CountW-1:0] count_nx;
  logic [ByteW-1:0]  first_nx;
  logic [HashW+CountW-1:0] count_ext;
  logic [HashW-1:0]  value;
  logic              need_fin;

  assign byte_ready_o = !full_i;
  assign take         = byte_valid_i && byte_ready_o;
  assign byte_ext     = {{(HashW-ByteW){1'b0}}, key_byte_i};

  // fold one byte with the mode of this byte
  always_comb begin
    oa_t1 = hash_q + byte_ext;
    oa_t2 = oa_t1 + (oa_t1 << 10);
    case (mode_i)
      MODE_SUM:  fold = hash_q + byte_ext;
      MODE_ROTX: fold = ((hash_q >> 1) | (hash_q << 7)) ^ byte_ext;
      default:   fold = oa_t2 ^ (oa_t2 >> 6);
    endcase
  end

  // saturating length and first byte of the key
  assign count_nx  = (count_q == '1) ? count_q : count_q + CountW'(1);
  assign first_nx  = start_q ? key_byte_i : first_q;
  assign count_ext = {{HashW{1'b0}}, count_nx};

  // value handed to the back end, with a flag for the avalanche step
  always_comb begin
    need_fin = 1'b0;
    case (mode_i)
      MODE_FIRST: value = {{(HashW-ByteW){1'b0}}, first_nx};
      MODE_LEN:   value = count_ext[HashW-1:0];
      MODE_SUM:   value = fold;
      MODE_ROTX:  value = fold;
      default: begin
        value    = fold;
        need_fin = 1'b1;
      end
    endcase
  end

  assign push_o  = take && key_end_i;
  assign entry_o = {need_fin, value};

  // per-key state update
  always_comb begin
    hash_d  = hash_q;
    count_d = count_q;
    first_d = first_q;
    start_d = start_q;
    if (take) begin
      if (key_end_i) begin
        hash_d  = '0;
        count_d = '0;
        first_d = '0;
        start_d = 1'b1;
      end else begin
        hash_d  = fold;
        count_d = count_nx;
        first_d = first_nx;
        start_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      count_q <= '0;
      first_q <= '0;
      start_q <= 1'b1;
    end else begin
      hash_q  <= hash_d;
      count_q <= count_d;
      first_q <= first_d;
      start_q <= start_d;
    end
  end

endmodule

>>> src/sbh_queue.sv
// sbh_queue: short register queue of finished keys between front and back
// no dependencies; generic width and depth
module sbh_queue #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !pop_i))
    else $error("key queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("key queue underflow");

endmodule

>>> src/sbh_back.sv
// sbh_back: avalanche finalisation, bit-serial modulo and result register
// depends on sbh_pkg
module sbh_back #(
  parameter int unsigned HashW = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sbh_pkg::BucketW-1:0] bucket_i,
  input  logic                        empty_i,
  input  logic [HashW:0]              entry_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [sbh_pkg::RawW-1:0]    raw_hash_o,
  output logic [sbh_pkg::BktIdxW-1:0] bucket_index_o
);
  import sbh_pkg::*;

  localparam int unsigned CntW = $clog2(HashW + 1);

  sbh_bk_state_e state_q, state_d;

  logic [HashW-1:0]   h_q;
  logic [BucketW-1:0] div_q;
  logic [BktIdxW-1:0] rem_q;
  logic [CntW-1:0]    cnt_q;

  logic               out_valid_q;
  logic [RawW-1:0]    out_raw_q;
  logic [BktIdxW-1:0] out_bkt_q;

  logic               load;
  logic [HashW-1:0]   fin1_t, fin1, fin2;
  logic [BucketW-1:0] trial, diff;
  logic [BktIdxW-1:0] rem_nx;
  logic [HashW+RawW-1:0] raw_ext;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!empty_i) state_d = entry_i[HashW] ? BK_FIN1 : BK_DIV;
      BK_FIN1: state_d = BK_FIN2;
      BK_FIN2: state_d = BK_DIV;
      BK_DIV:  if (cnt_q == CntW'(1)) state_d = BK_OUT;
      BK_OUT:  if (!out_valid_q || res_ready_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o = 1'b0;
    load  = 1'b0;
    unique case (state_q)
      BK_IDLE: pop_o = !empty_i;
      BK_OUT:  load  = !out_valid_q || res_ready_i;
      default: begin
        pop_o = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // avalanche steps, split over the states BK_FIN1 and BK_FIN2
  assign fin1_t = h_q + (h_q << 3);
  assign fin1   = fin1_t ^ (fin1_t >> 11);
  assign fin2   = h_q + (h_q << 15);

  // one restoring division step per cycle, hash bits msb first
  assign trial  = {rem_q, h_q[HashW-1]};
  assign diff   = trial - div_q;
  assign rem_nx = (trial >= div_q) ? diff[BktIdxW-1:0] : trial[BktIdxW-1:0];

  // working registers; the hash rotates through the divider and ends unchanged
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          h_q   <= entry_i[HashW-1:0];
          div_q <= clamp_bucket(bucket_i);
          rem_q <= '0;
          cnt_q <= CntW'(HashW);
        end
      end
      BK_FIN1: h_q <= fin1;
      BK_FIN2: h_q <= fin2;
      BK_DIV: begin
        h_q   <= {h_q[HashW-2:0], h_q[HashW-1]};
        rem_q <= rem_nx;
        cnt_q <= cnt_q - CntW'(1);
      end
      default: begin
        h_q <= h_q;
      end
    endcase
  end

  // result register
  assign raw_ext = {{RawW{1'b0}}, h_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_raw_q <= raw_ext[RawW-1:0];
      out_bkt_q <= rem_q;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign raw_hash_o     = out_raw_q;
  assign bucket_index_o = out_bkt_q;

  a_div_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (cnt_q != '0))
    else $error("divider running with no bits left");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT) |-> ({1'b0, rem_q} < div_q))
    else $error("bucket index not below bucket count");

endmodule

>>> src/string_bucket_hash_engine_core.sv
// string_bucket_hash_engine_core: top level of the string bucket hash engine
// holds the configuration registers; uses sbh_pkg, sbh_front, sbh_queue, sbh_back
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata key_byte, tlast key_end
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata raw_hash, bucket_index
//   cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// key bytes are taken one per cycle while the key queue has room; the front fold
// updates the running hash register on each accepted byte but a key's last, which clears it.
// each key passes the back end in order: a pop in BK_IDLE, BK_FIN1 and BK_FIN2 for
// one-at-a-time finalisation only, one bit-serial modulo step per hash bit, then BK_OUT.
// a result waits in the output register while the front keeps taking bytes until the key queue is full.
// reset is asynchronous active low and needs no clearing pass.
module string_bucket_hash_engine_core #(
  parameter int unsigned HASH_WIDTH  = 32,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] key_byte
  input  logic                         s_axis_tlast,  // key_end
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sbh_pkg::OutDataW-1:0] m_axis_tdata,  // [31:0] raw_hash, [55:32] bucket_index
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sbh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sbh_pkg::CfgDataW-1:0] cfg_data_i
);
  import sbh_pkg::*;

  logic [ModeW-1:0]   mode_q;
  logic [BucketW-1:0] bucket_q;
  sbh_mode_e          mode;

  logic               push, pop, full, empty;
  logic [HASH_WIDTH:0] push_entry, pop_entry;
  logic [RawW-1:0]    raw_hash;
  logic [BktIdxW-1:0] bucket_index;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OAAT;
      bucket_q <= BucketReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HASH_MODE:    mode_q   <= cfg_data_i[ModeW-1:0];
        CFG_BUCKET_COUNT: bucket_q <= cfg_data_i[BucketW-1:0];
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  assign mode = clamp_mode(mode_q);

  // byte front end
  sbh_front #(
    .HashW(HASH_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .mode_i       (mode),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .key_byte_i   (s_axis_tdata),
    .key_end_i    (s_axis_tlast),
    .push_o       (push),
    .entry_o      (push_entry),
    .full_i       (full)
  );

  // finished keys awaiting the back end
  sbh_queue #(
    .Width(HASH_WIDTH + 1),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (empty)
  );

  // finalisation and bucket reduction
  sbh_back #(
    .HashW(HASH_WIDTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .bucket_i       (bucket_q),
    .empty_i        (empty),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .raw_hash_o     (raw_hash),
    .bucket_index_o (bucket_index)
  );

  assign m_axis_tdata = {bucket_index, raw_hash};

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for string_bucket_hash_engine_core
// streams keys byte by byte, predicts raw hash and bucket index per key, checks every result
// depends on sbh_pkg and string_bucket_hash_engine_core
module tb_top;
  import sbh_pkg::*;

  localparam int unsigned BackEndCycles = 1 + 32 + 1 + 2;
  localparam int unsigned SettleCycles  = 2 * BackEndCycles + 8;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    logic [BktIdxW-1:0] bucket;
    logic [RawW-1:0]    raw;
  } key_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] key_byte
  logic                s_axis_tlast;   // key_end
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [31:0] raw_hash, [55:32] bucket_index
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // shadow of the block: registers and per-key state
  logic [ModeW-1:0]   mode_reg;
  logic [BucketW-1:0] bucket_reg;
  logic [31:0]        key_hash;
  logic [CountW-1:0]  key_len;
  logic [ByteW-1:0]   key_first;
  logic               key_fresh;
  key_result_t        pending_results[$];

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned keys_checked;
  int unsigned cycle_count;

  string_bucket_hash_engine_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker against the oldest expected key result
  always @(posedge clk_i) begin
    key_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: raw_hash %h bucket_index %h",
               m_axis_tdata[31:0], m_axis_tdata[55:32]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        keys_checked++;
        if (m_axis_tdata[31:0] !== want.raw) begin
          $error("raw_hash expected %h actual %h", want.raw, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[55:32] !== want.bucket) begin
          $error("bucket_index expected %h actual %h", want.bucket, m_axis_tdata[55:32]);
          fail_count++;
        end
      end
    end
  end

  // unused mode codes fall back to one-at-a-time
  function automatic sbh_mode_e active_mode(input logic [ModeW-1:0] code);
    if (code > ModeW'(MODE_OAAT)) return MODE_OAAT;
    return sbh_mode_e'(code);
  endfunction

  // per-byte update of the running hash
  function automatic logic [31:0] fold_in(input logic [31:0] h, input logic [7:0] b,
                                          input sbh_mode_e m);
    logic [31:0] x;
    case (m)
      MODE_SUM:  x = h + 32'(b);
      MODE_ROTX: x = ((h >> 1) | (h << 7)) ^ 32'(b);
      default: begin
        x = h + 32'(b);
        x = x + (x << 10);
        x = x ^ (x >> 6);
      end
    endcase
    return x;
  endfunction

  // hash value at the key's last byte
  function automatic logic [31:0] key_digest(input sbh_mode_e m);
    logic [31:0] x;
    case (m)
      MODE_FIRST: x = 32'(key_first);
      MODE_LEN:   x = key_len;
      MODE_SUM,
      MODE_ROTX:  x = key_hash;
      default: begin
        x = key_hash + (key_hash << 3);
        x = x ^ (x >> 11);
        x = x + (x << 15);
      end
    endcase
    return x;
  endfunction

  // predict the effect of one accepted byte
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    sbh_mode_e   m;
    logic [24:0] modulus;
    key_result_t res;
    m = active_mode(mode_reg);
    if (key_fresh) key_first = b;
    key_fresh = 1'b0;
    if (key_len != '1) key_len++;
    key_hash = fold_in(key_hash, b, m);
    if (last) begin
      modulus = bucket_reg;
      if (modulus == '0) modulus = 25'd1;
      if (modulus > 25'h100_0000) modulus = 25'h100_0000;
      res.raw    = key_digest(m);
      res.bucket = BktIdxW'(res.raw % 32'(modulus));
      pending_results.push_back(res);
      key_hash  = '0;
      key_len   = '0;
      key_first = '0;
      key_fresh = 1'b1;
    end
  endfunction

  // one key byte; the valid line stays up for a following item
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_key(input logic [7:0] key_bytes[$]);
    foreach (key_bytes[i]) push_byte(key_bytes[i], i == key_bytes.size() - 1);
  endtask

  // stop sending and wait for every expected result plus back-end latency
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_HASH_MODE:    mode_reg = data[ModeW-1:0];
      CFG_BUCKET_COUNT: bucket_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_bucket_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 25'd1;
      2:       return 25'h100_0000;
      3:       return CfgDataW'($urandom);
      4, 5:    return CfgDataW'($urandom_range(16, 2));
      default: return CfgDataW'($urandom_range(25'h100_0000, 1));
    endcase
  endfunction

  task automatic program_random();
    write_reg(CFG_HASH_MODE, {22'($urandom), 3'($urandom_range(7))});
    write_reg(CFG_BUCKET_COUNT, pick_bucket_count());
  endtask

  // keys after reset use the reset mode and bucket count
  task automatic test_reset_defaults();
    send_key('{8'h00});
    send_key('{8'hFF});
    send_key('{8'h61, 8'h62, 8'h63});
    drain();
  endtask

  // every mode code, unused ones included
  task automatic test_each_mode();
    for (int code = 0; code < 8; code++) begin
      write_reg(CFG_HASH_MODE, CfgDataW'(code));
      send_key('{8'hFF, 8'h01});
      drain();
    end
  endtask

  // zero, one, the maximum, one below it and oversized bucket counts
  task automatic test_bucket_extremes();
    logic [CfgDataW-1:0] counts[5] = '{25'd0, 25'd1, 25'h100_0000, 25'h0FF_FFFF, 25'h1FF_FFFF};
    write_reg(CFG_HASH_MODE, CfgDataW'(MODE_OAAT));
    foreach (counts[i]) begin
      write_reg(CFG_BUCKET_COUNT, counts[i]);
      send_key('{pick_byte()});
      drain();
    end
  endtask

  // mode switched between two bytes of one key
  task automatic test_mode_switch_mid_key();
    write_reg(CFG_BUCKET_COUNT, 25'd997);
    write_reg(CFG_HASH_MODE, CfgDataW'(MODE_SUM));
    push_byte(8'h7F, 1'b0);
    drain();
    write_reg(CFG_HASH_MODE, CfgDataW'(MODE_ROTX));
    push_byte(8'h81, 1'b1);
    drain();
  endtask

  // writes to unmapped indexes leave both registers alone
  task automatic test_unmapped_index();
    write_reg(CFG_UNMAPPED_LO, '1);
    write_reg(CFG_UNMAPPED_HI, '0);
    send_key('{8'h5A, 8'hA5});
    drain();
  endtask

  // random keys under one idling mix, reprogrammed every few dozen bytes
  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input int unsigned n_items);
    logic [7:0]  key_bytes[$];
    int unsigned start;
    int unsigned since_cfg;
    int unsigned len;
    gap_pct   = gap;
    stall_pct = stall;
    start     = bytes_sent;
    since_cfg = 0;
    program_random();
    while (bytes_sent - start < n_items) begin
      if (since_cfg >= 50) begin
        drain();
        program_random();
        since_cfg = 0;
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
      key_bytes.delete();
      repeat (len) key_bytes.push_back(pick_byte());
      send_key(key_bytes);
      since_cfg += len;
    end
    drain();
  endtask

  // long receiver hold-off so the queue fills and the input stalls
  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(CFG_HASH_MODE, CfgDataW'(MODE_OAAT));
    write_reg(CFG_BUCKET_COUNT, 25'd13);
    @(posedge clk_i);
    hold_req = 600;
    @(negedge clk_i);
    repeat (40) send_key('{pick_byte()});
    drain();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mode_reg      = ModeW'(MODE_OAAT);
    bucket_reg    = BucketReset;
    key_hash      = '0;
    key_len       = '0;
    key_first     = '0;
    key_fresh     = 1'b1;
    gap_pct       = 0;
    stall_pct     = 0;
    hold_req      = 0;
    hold_left     = 0;
    fail_count    = 0;
    bytes_sent    = 0;
    keys_checked  = 0;
    cycle_count   = 0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_each_mode();
    test_bucket_extremes();
    test_mode_switch_mid_key();
    test_unmapped_index();
    test_random_traffic(0, 0, 150);
    test_random_traffic(64, 0, 150);
    test_random_traffic(0, 64, 150);
    test_random_traffic(21, 21, 150);
    test_backpressure();

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    $display("covered %0d key bytes and %0d checked keys in %0d cycles", bytes_sent,
             keys_checked, cycle_count);
    $display("all eight mode codes, bucket count limits, mid-key mode change, stalls on both sides");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
